/* rtl/core/kvlp_pkg.sv */
package kvlp_pkg;

   // Width of one text byte and of one emitted character.
   localparam int BYTE_W = 8;

   // Default buffer sizes, terminator included.
   localparam int KEY_SIZE_DEF   = 16;
   localparam int VALUE_SIZE_DEF = 32;

   // Characters the parser reacts to.
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CH_EQUAL = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_N     = 8'h6E;

endpackage

/* rtl/core/key_value_line_parser.sv */
// Key/value line parser.
// The req channel takes one text byte per item; a zero byte ends the text and
// also closes any open line. Bytes of a line are taken one per cycle while the
// block is idle; the key and value characters are written into two small
// synchronous memories as they arrive.
// At a line feed or a zero byte the block stops taking items and drains the
// accepted line on the rsp channel: key characters, then value characters,
// then an end marker for a zero byte, with last set on the final item.
// The drain reads the memories at one read per cycle while the output
// register is free; each read is registered and then moves into the output
// register. Items of one part follow one per cycle when the receiver does
// not stall. req_ready stays low until the last item has left the read
// stage and the drain returns to idle.
// A value byte that follows a backslash other than 'n' or a backslash
// goes through S_HOLD to write two characters through the single write port.
// A stalled receiver holds the output register and with it the drain.
// Reset returns the parser to the start of a line with nothing buffered.
module key_value_line_parser #(
   parameter int KEY_SIZE   = kvlp_pkg::KEY_SIZE_DEF,
   parameter int VALUE_SIZE = kvlp_pkg::VALUE_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [kvlp_pkg::BYTE_W-1:0] req_text_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [kvlp_pkg::BYTE_W-1:0] rsp_out_char,
   output logic                        rsp_is_value,
   output logic                        rsp_end_of_text,
   output logic                        rsp_last
);

   localparam int KCW = $clog2(KEY_SIZE);
   localparam int VCW = $clog2(VALUE_SIZE);
   localparam logic [KCW-1:0] KMAX = KCW'(KEY_SIZE - 1);
   localparam logic [VCW-1:0] VMAX = VCW'(VALUE_SIZE - 1);

   typedef enum logic [2:0] {
      PH_LEAD, PH_SKIP, PH_KEY, PH_VLEAD, PH_VAL
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE, S_HOLD, S_KEY, S_VAL, S_EOT
   } state_type;

   typedef logic [kvlp_pkg::BYTE_W-1:0] byte_type;

   // Character memories.
   byte_type key_mem [KEY_SIZE];
   byte_type val_mem [VALUE_SIZE];
   byte_type krd_ff, vrd_ff;

   // Control state.
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [KCW-1:0] key_count_ff, key_count_in, key_keep_ff, key_keep_in;
   logic [VCW-1:0] val_count_ff, val_count_in, val_keep_ff, val_keep_in;
   logic           esc_ff, esc_in;
   byte_type       hold_ff, hold_in;
   logic [KCW-1:0] klen_ff, klen_in, kidx_ff, kidx_in;
   logic [VCW-1:0] vlen_ff, vlen_in, vidx_ff, vidx_in;
   logic           eot_flag_ff, eot_flag_in;

   // Read pipeline tags and output register.
   logic     rd_pending_ff, rd_pending_in;
   logic     tag_value_ff, tag_value_in;
   logic     tag_eot_ff, tag_eot_in;
   logic     tag_last_ff, tag_last_in;
   logic     rsp_valid_ff;
   byte_type rsp_char_ff;
   logic     rsp_is_value_ff, rsp_eot_ff, rsp_last_ff;

   // Per-cycle decisions.
   byte_type c;
   logic     accept, end_byte, c_blank, emit_line;
   logic     kpush, vpush, vpush_keep;
   byte_type vpush_char;
   logic     k_full, v_full;
   logic [KCW-1:0] k_keep_new, k_count_new, kidx_nx;
   logic [VCW-1:0] v_keep_new, v_count_new, vidx_nx;
   logic     out_free, move, can_issue, k_issue, v_issue, e_issue;

   assign c         = req_text_byte;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign end_byte  = (c == kvlp_pkg::CH_NUL) || (c == kvlp_pkg::CH_LF);
   assign c_blank   = (c == kvlp_pkg::CH_SPACE) || (c == kvlp_pkg::CH_TAB);
   assign emit_line = (phase_ff == PH_VLEAD) || (phase_ff == PH_VAL);

   // Decide which store, if any, takes a character this cycle.
   always_comb begin
      kpush      = 1'b0;
      vpush      = 1'b0;
      vpush_keep = 1'b1;
      vpush_char = c;
      if (state_ff == S_HOLD) begin
         vpush      = 1'b1;
         vpush_char = hold_ff;
         vpush_keep = !((hold_ff == kvlp_pkg::CH_SPACE) || (hold_ff == kvlp_pkg::CH_TAB)
                        || (hold_ff == kvlp_pkg::CH_CR));
      end else if (accept) begin
         if (end_byte) begin
            // A dangling backslash is kept as a literal one.
            vpush      = esc_ff;
            vpush_char = kvlp_pkg::CH_BSL;
         end else begin
            case (phase_ff)
               PH_LEAD: begin
                  kpush = !c_blank && (c != kvlp_pkg::CH_HASH) && (c != kvlp_pkg::CH_CR)
                          && (c != kvlp_pkg::CH_EQUAL);
               end
               PH_KEY: begin
                  kpush = (c != kvlp_pkg::CH_EQUAL);
               end
               PH_VLEAD: begin
                  vpush      = !c_blank && (c != kvlp_pkg::CH_BSL);
                  vpush_keep = (c != kvlp_pkg::CH_CR);
               end
               PH_VAL: begin
                  if (esc_ff) begin
                     // Escaped newline, escaped backslash, or a literal backslash first.
                     vpush      = 1'b1;
                     vpush_char = (c == kvlp_pkg::CH_N) ? kvlp_pkg::CH_LF : kvlp_pkg::CH_BSL;
                  end else begin
                     vpush      = (c != kvlp_pkg::CH_BSL);
                     vpush_keep = !c_blank && (c != kvlp_pkg::CH_CR);
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Counters and trimmed lengths after this cycle's push.
   always_comb begin
      k_full      = (key_count_ff == KMAX);
      v_full      = (val_count_ff == VMAX);
      k_keep_new  = key_keep_ff;
      k_count_new = key_count_ff;
      v_keep_new  = val_keep_ff;
      v_count_new = val_count_ff;
      if (kpush) begin
         if (!c_blank) begin
            k_keep_new = k_full ? key_count_ff : key_count_ff + 1'b1;
         end
         if (!k_full) begin
            k_count_new = key_count_ff + 1'b1;
         end
      end
      if (vpush) begin
         if (vpush_keep) begin
            v_keep_new = v_full ? val_count_ff : val_count_ff + 1'b1;
         end
         if (!v_full) begin
            v_count_new = val_count_ff + 1'b1;
         end
      end
   end

   // Drain read issue: one read in flight, held until the output takes it.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign move      = rd_pending_ff && out_free;
   assign can_issue = !rd_pending_ff || move;
   assign k_issue   = (state_ff == S_KEY) && (kidx_ff != klen_ff) && can_issue;
   assign v_issue   = (state_ff == S_VAL) && (vidx_ff != vlen_ff) && can_issue;
   assign e_issue   = (state_ff == S_EOT) && eot_flag_ff && can_issue;
   assign kidx_nx   = kidx_ff + 1'b1;
   assign vidx_nx   = vidx_ff + 1'b1;

   // Next-state logic for the parser and the drain sequencer.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      key_count_in  = k_count_new;
      key_keep_in   = k_keep_new;
      val_count_in  = v_count_new;
      val_keep_in   = v_keep_new;
      esc_in        = esc_ff;
      hold_in       = hold_ff;
      klen_in       = klen_ff;
      vlen_in       = vlen_ff;
      kidx_in       = kidx_ff;
      vidx_in       = vidx_ff;
      eot_flag_in   = eot_flag_ff;
      rd_pending_in = k_issue || v_issue || e_issue || (rd_pending_ff && !move);
      tag_value_in  = tag_value_ff;
      tag_eot_in    = tag_eot_ff;
      tag_last_in   = tag_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (end_byte) begin
                  // Latch what to emit, then start a fresh line.
                  klen_in      = emit_line ? key_keep_ff : '0;
                  vlen_in      = emit_line ? v_keep_new : '0;
                  eot_flag_in  = (c == kvlp_pkg::CH_NUL);
                  kidx_in      = '0;
                  vidx_in      = '0;
                  phase_in     = PH_LEAD;
                  key_count_in = '0;
                  key_keep_in  = '0;
                  val_count_in = '0;
                  val_keep_in  = '0;
                  esc_in       = 1'b0;
                  state_in     = S_KEY;
               end else begin
                  case (phase_ff)
                     PH_LEAD: begin
                        if (!c_blank) begin
                           phase_in = kpush ? PH_KEY : PH_SKIP;
                        end
                     end
                     PH_KEY: begin
                        if (c == kvlp_pkg::CH_EQUAL) begin
                           phase_in = (key_keep_ff == '0) ? PH_SKIP : PH_VLEAD;
                        end
                     end
                     PH_VLEAD: begin
                        if (!c_blank) begin
                           phase_in = PH_VAL;
                           esc_in   = (c == kvlp_pkg::CH_BSL);
                        end
                     end
                     PH_VAL: begin
                        if (esc_ff) begin
                           esc_in = 1'b0;
                           if ((c != kvlp_pkg::CH_N) && (c != kvlp_pkg::CH_BSL)) begin
                              hold_in  = c;
                              state_in = S_HOLD;
                           end
                        end else begin
                           esc_in = (c == kvlp_pkg::CH_BSL);
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         S_HOLD: begin
            state_in = S_IDLE;
         end
         S_KEY: begin
            if (kidx_ff == klen_ff) begin
               state_in = S_VAL;
            end else if (k_issue) begin
               kidx_in      = kidx_nx;
               tag_value_in = 1'b0;
               tag_eot_in   = 1'b0;
               tag_last_in  = (kidx_nx == klen_ff) && (vlen_ff == '0) && !eot_flag_ff;
            end
         end
         S_VAL: begin
            if (vidx_ff == vlen_ff) begin
               state_in = S_EOT;
            end else if (v_issue) begin
               vidx_in      = vidx_nx;
               tag_value_in = 1'b1;
               tag_eot_in   = 1'b0;
               tag_last_in  = (vidx_nx == vlen_ff) && !eot_flag_ff;
            end
         end
         S_EOT: begin
            if (e_issue) begin
               eot_flag_in  = 1'b0;
               tag_value_in = 1'b0;
               tag_eot_in   = 1'b1;
               tag_last_in  = 1'b1;
            end else if (!eot_flag_ff && (!rd_pending_ff || move)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_LEAD;
         key_count_ff  <= '0;
         key_keep_ff   <= '0;
         val_count_ff  <= '0;
         val_keep_ff   <= '0;
         esc_ff        <= 1'b0;
         klen_ff       <= '0;
         vlen_ff       <= '0;
         kidx_ff       <= '0;
         vidx_ff       <= '0;
         eot_flag_ff   <= 1'b0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         key_count_ff  <= key_count_in;
         key_keep_ff   <= key_keep_in;
         val_count_ff  <= val_count_in;
         val_keep_ff   <= val_keep_in;
         esc_ff        <= esc_in;
         klen_ff       <= klen_in;
         vlen_ff       <= vlen_in;
         kidx_ff       <= kidx_in;
         vidx_ff       <= vidx_in;
         eot_flag_ff   <= eot_flag_in;
         rd_pending_ff <= rd_pending_in;
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      hold_ff      <= hold_in;
      tag_value_ff <= tag_value_in;
      tag_eot_ff   <= tag_eot_in;
      tag_last_ff  <= tag_last_in;
      if (move) begin
         rsp_char_ff     <= tag_eot_ff ? kvlp_pkg::CH_NUL : (tag_value_ff ? vrd_ff : krd_ff);
         rsp_is_value_ff <= tag_value_ff;
         rsp_eot_ff      <= tag_eot_ff;
         rsp_last_ff     <= tag_last_ff;
      end
   end

   // Key memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (kpush && !k_full) begin
         key_mem[key_count_ff] <= c;
      end
      if (k_issue) begin
         krd_ff <= key_mem[kidx_ff];
      end
   end

   // Value memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (vpush && !v_full) begin
         val_mem[val_count_ff] <= vpush_char;
      end
      if (v_issue) begin
         vrd_ff <= val_mem[vidx_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_is_value    = rsp_is_value_ff;
   assign rsp_end_of_text = rsp_eot_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
